// File: rtl/rbc_pkg.sv
// Shared constants and widths for the recurrence byte checksum.
`default_nettype none

package rbc_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned TermWidth  = 16;
   localparam int unsigned SumWidth   = 9;
   localparam int unsigned LhsWidth   = SumWidth + TermWidth;
   localparam int unsigned RhsWidth   = ByteWidth + TermWidth;
   localparam int unsigned WideWidth  = LhsWidth + 1;

   localparam logic [ByteWidth-1:0] StartOffset = 8'd7;
   localparam logic [TermWidth-1:0] TermReset   = 16'd1;
   localparam logic [TermWidth-1:0] Modulus     = 16'hFFFF;

   // A multiple of the modulus that exceeds any subtracted product.
   localparam logic [RhsWidth-1:0] ModBias = 24'd16776960;

endpackage

`default_nettype wire

// File: rtl/rbc_term.sv
// Next-term logic: coefficients, two products and the reduction mod 65535.
`default_nettype none

module rbc_term (
   input  wire logic [rbc_pkg::ByteWidth-1:0] data_byte,
   input  wire logic                          at_start,
   input  wire logic [rbc_pkg::ByteWidth-1:0] position,
   input  wire logic [rbc_pkg::TermWidth-1:0] term_cur,
   input  wire logic [rbc_pkg::TermWidth-1:0] term_prev,
   output logic      [rbc_pkg::TermWidth-1:0] term_next
);

   logic [rbc_pkg::ByteWidth-1:0] alpha;
   logic [rbc_pkg::ByteWidth-1:0] beta;
   logic [rbc_pkg::SumWidth-1:0]  factor;
   logic [rbc_pkg::LhsWidth-1:0]  lhs;
   logic [rbc_pkg::RhsWidth-1:0]  rhs;
   logic                          negative;
   logic [rbc_pkg::WideWidth-1:0] wide;
   logic [rbc_pkg::TermWidth:0]   fold1;
   logic [rbc_pkg::TermWidth-1:0] fold2;
   logic [rbc_pkg::TermWidth-1:0] reduced;

   always_comb begin
      alpha    = position + {position[3:0], 4'd0};
      beta     = {position[2:0], 5'd0} - position;
      factor   = {1'b0, data_byte} + {1'b0, alpha};
      lhs      = {{(rbc_pkg::LhsWidth-rbc_pkg::SumWidth){1'b0}}, factor}
               * {{(rbc_pkg::LhsWidth-rbc_pkg::TermWidth){1'b0}}, term_cur};
      rhs      = {{(rbc_pkg::RhsWidth-rbc_pkg::ByteWidth){1'b0}}, beta}
               * {{(rbc_pkg::RhsWidth-rbc_pkg::TermWidth){1'b0}}, term_prev};
      negative = lhs < {1'b0, rhs};
      // A wrapped negative difference adds one, since 2^64 mod 65535 is one.
      wide     = {1'b0, lhs} + {2'b0, rbc_pkg::ModBias} - {2'b0, rhs}
               + {{(rbc_pkg::WideWidth-1){1'b0}}, negative};
      fold1    = {1'b0, wide[rbc_pkg::TermWidth-1:0]}
               + {{(2*rbc_pkg::TermWidth+1-rbc_pkg::WideWidth){1'b0}},
                  wide[rbc_pkg::WideWidth-1:rbc_pkg::TermWidth]};
      fold2    = fold1[rbc_pkg::TermWidth-1:0]
               + {{(rbc_pkg::TermWidth-1){1'b0}}, fold1[rbc_pkg::TermWidth]};
      reduced  = (fold2 == rbc_pkg::Modulus) ? '0 : fold2;
      if (at_start) begin
         term_next = {{(rbc_pkg::TermWidth-rbc_pkg::ByteWidth){1'b0}}, data_byte}
                   + {{(rbc_pkg::TermWidth-rbc_pkg::ByteWidth){1'b0}},
                      rbc_pkg::StartOffset};
      end else begin
         term_next = reduced;
      end
   end

endmodule

`default_nettype wire

// File: rtl/recurrence_byte_checksum_top.sv
// Top level of the recurrence byte checksum: input register, state and result register.
//
//   Channel  Direction  Beat fields                Flow control
//   req      in         req_data_byte, req_last_byte  req_valid / req_stall
//   rsp      out        rsp_checksum               rsp_valid / rsp_stall
//
// A byte is held in the input register, and its term is computed and the state
// updated as it leaves, so one byte is taken every cycle unless a checksum is stalled.
// A checksum is loaded into the result register as its final byte leaves the input register.
// Synchronous reset clears both valid flags and rearms the state.
// While a checksum is stalled, the byte in the input register is held.
`default_nettype none

module recurrence_byte_checksum_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [rbc_pkg::ByteWidth-1:0] req_data_byte,
   input  wire logic                          req_last_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [rbc_pkg::TermWidth-1:0] rsp_checksum
);

   logic                          in_valid_ff, in_valid_in;
   logic [rbc_pkg::ByteWidth-1:0] in_byte_ff;
   logic                          in_last_ff;
   logic [rbc_pkg::TermWidth-1:0] term_prev_ff, term_prev_in;
   logic [rbc_pkg::TermWidth-1:0] term_cur_ff, term_cur_in;
   logic [rbc_pkg::ByteWidth-1:0] position_ff, position_in;
   logic                          at_start_ff, at_start_in;
   logic                          out_valid_ff, out_valid_in;
   logic [rbc_pkg::TermWidth-1:0] out_sum_ff;
   logic [rbc_pkg::TermWidth-1:0] term_next;
   logic                          out_free;
   logic                          advance;
   logic                          req_take;

   rbc_term u_term (
      .data_byte (in_byte_ff),
      .at_start  (at_start_ff),
      .position  (position_ff),
      .term_cur  (term_cur_ff),
      .term_prev (term_prev_ff),
      .term_next (term_next)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      advance   = in_valid_ff && out_free;
      req_stall = in_valid_ff && !advance;
      req_take  = req_valid && !req_stall;

      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = (advance && in_last_ff) || (out_valid_ff && !out_free);

      term_prev_in = term_prev_ff;
      term_cur_in  = term_cur_ff;
      position_in  = position_ff;
      at_start_in  = at_start_ff;
      if (advance) begin
         if (in_last_ff) begin
            term_prev_in = rbc_pkg::TermReset;
            term_cur_in  = rbc_pkg::TermReset;
            position_in  = '0;
            at_start_in  = 1'b1;
         end else begin
            term_prev_in = at_start_ff ? rbc_pkg::TermReset : term_cur_ff;
            term_cur_in  = term_next;
            position_in  = position_ff + 8'd1;
            at_start_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         term_prev_ff <= rbc_pkg::TermReset;
         term_cur_ff  <= rbc_pkg::TermReset;
         position_ff  <= '0;
         at_start_ff  <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         term_prev_ff <= term_prev_in;
         term_cur_ff  <= term_cur_in;
         position_ff  <= position_in;
         at_start_ff  <= at_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         out_sum_ff <= term_next;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_checksum = out_sum_ff;

endmodule

`default_nettype wire

// File: tb/recurrence_byte_checksum_top_tb.sv
// Self-checking testbench for the recurrence byte checksum with random idling on both sides.
`timescale 1ns / 100ps

module recurrence_byte_checksum_top_tb;

   localparam int unsigned RandomBytes   = 1500;
   localparam int unsigned CalmTailBytes = 150;
   localparam int unsigned DirectedRows  = 16;
   localparam int unsigned DrainLimit    = 10000;

   typedef struct packed {
      logic [rbc_pkg::ByteWidth-1:0] data;
      logic                          fin;
      logic                          typed;
      logic [rbc_pkg::TermWidth-1:0] sum;
   } stim_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [rbc_pkg::ByteWidth-1:0] req_data_byte;
   logic                          req_last_byte;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [rbc_pkg::TermWidth-1:0] rsp_checksum;

   logic [rbc_pkg::TermWidth-1:0] sum_prev;
   logic [rbc_pkg::TermWidth-1:0] sum_cur;
   logic [rbc_pkg::ByteWidth-1:0] byte_pos;
   logic                          awaiting_first;

   logic [rbc_pkg::TermWidth-1:0] pending_sums[$];
   stim_row_type                  directed_rows[DirectedRows];

   bit                   quiet;
   bit                   send_calm;
   int unsigned          errors;
   int unsigned          bytes_sent;
   int unsigned          messages_sent;
   int unsigned          sums_checked;
   int unsigned          longest_msg;
   int unsigned          msg_len;

   recurrence_byte_checksum_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_checksum  (rsp_checksum)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** recurrence_byte_checksum_top: FAILED **");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic void advance_checksum(input logic [rbc_pkg::ByteWidth-1:0] b,
                                            input logic fin,
                                            output logic done,
                                            output logic [rbc_pkg::TermWidth-1:0] sum);
      logic [rbc_pkg::ByteWidth-1:0] weight_a;
      logic [rbc_pkg::ByteWidth-1:0] weight_b;
      logic [63:0]                   lhs;
      logic [63:0]                   rhs;
      logic [63:0]                   diff;
      if (awaiting_first) begin
         sum_prev       = 16'd1;
         sum_cur        = 16'(b) + 16'd7;
         byte_pos       = 8'd1;
         awaiting_first = 1'b0;
      end else begin
         weight_a = byte_pos * 8'd17;
         weight_b = byte_pos * 8'd31;
         lhs      = (64'(b) + 64'(weight_a)) * 64'(sum_cur);
         rhs      = 64'(weight_b) * 64'(sum_prev);
         diff     = lhs - rhs;
         diff     = diff % 64'd65535;
         sum_prev = sum_cur;
         sum_cur  = diff[rbc_pkg::TermWidth-1:0];
         byte_pos = byte_pos + 8'd1;
      end
      done = fin;
      sum  = sum_cur;
      if (fin) begin
         sum_prev       = 16'd1;
         sum_cur        = 16'd1;
         byte_pos       = 8'd0;
         awaiting_first = 1'b1;
      end
   endfunction

   task automatic push_byte(input logic [rbc_pkg::ByteWidth-1:0] b, input logic fin,
                            input logic typed,
                            input logic [rbc_pkg::TermWidth-1:0] typed_sum);
      logic                          done;
      logic [rbc_pkg::TermWidth-1:0] sum;
      if (!quiet && !send_calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_checksum(b, fin, done, sum);
      if (done) pending_sums.push_back(typed ? typed_sum : sum);
      bytes_sent++;
      msg_len++;
      if (fin) begin
         messages_sent++;
         if (msg_len > longest_msg) longest_msg = msg_len;
         msg_len = 0;
      end
   endtask

   initial begin : rsp_backpressure
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 80)) @(posedge clock);
         end
      end
   end

   initial begin : checksum_monitor
      logic [rbc_pkg::TermWidth-1:0] want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_sums.size() == 0) begin
               report_mismatch($sformatf("unexpected checksum %0d", rsp_checksum));
            end else begin
               want = pending_sums.pop_front();
               sums_checked++;
               if (rsp_checksum !== want)
                  report_mismatch($sformatf("checksum %0d, expected %0d", rsp_checksum, want));
            end
         end
      end
   end

   initial begin : stimulus
      logic [rbc_pkg::ByteWidth-1:0] b;
      int unsigned                   len;
      int unsigned                   msg_idx;
      int unsigned                   drain;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_data_byte  <= '0;
      req_last_byte  <= 1'b0;
      quiet          = 1'b0;
      send_calm      = 1'b0;
      errors         = 0;
      bytes_sent     = 0;
      messages_sent  = 0;
      sums_checked   = 0;
      longest_msg    = 0;
      msg_len        = 0;
      sum_prev       = 16'd1;
      sum_cur        = 16'd1;
      byte_pos       = 8'd0;
      awaiting_first = 1'b1;

      // Single-byte messages, the shortest two-byte message, a negative difference
      // at the third byte, and bytes that toggle every bit.
      directed_rows = '{
         '{8'd0,   1'b1, 1'b1, 16'd7},
         '{8'd255, 1'b1, 1'b1, 16'd262},
         '{8'd128, 1'b1, 1'b1, 16'd135},
         '{8'd0,   1'b0, 1'b0, 16'd0},
         '{8'd0,   1'b1, 1'b1, 16'd88},
         '{8'd255, 1'b0, 1'b0, 16'd0},
         '{8'd234, 1'b0, 1'b0, 16'd0},
         '{8'd0,   1'b1, 1'b0, 16'd0},
         '{8'd255, 1'b0, 1'b0, 16'd0},
         '{8'd255, 1'b1, 1'b0, 16'd0},
         '{8'h55,  1'b0, 1'b0, 16'd0},
         '{8'hAA,  1'b0, 1'b0, 16'd0},
         '{8'h0F,  1'b0, 1'b0, 16'd0},
         '{8'hF0,  1'b0, 1'b0, 16'd0},
         '{8'h01,  1'b0, 1'b0, 16'd0},
         '{8'h80,  1'b1, 1'b0, 16'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int unsigned r = 0; r < DirectedRows; r++)
         push_byte(directed_rows[r].data, directed_rows[r].fin,
                   directed_rows[r].typed, directed_rows[r].sum);

      // Mostly short messages; an occasional long one runs the position past its wrap.
      msg_idx = 0;
      while (bytes_sent < RandomBytes + DirectedRows) begin
         if (msg_idx == 2 || $urandom_range(0, 24) == 0) len = $urandom_range(257, 320);
         else len = $urandom_range(1, 16);
         send_calm = ($urandom_range(0, 4) == 0);
         for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else b = 8'($urandom_range(0, 255));
            quiet = (bytes_sent + CalmTailBytes >= RandomBytes + DirectedRows);
            push_byte(b, k == len - 1, 1'b0, '0);
         end
         msg_idx++;
      end
      req_valid <= 1'b0;

      drain = 0;
      while (pending_sums.size() != 0 && drain < DrainLimit) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      if (pending_sums.size() != 0)
         report_mismatch($sformatf("%0d checksums never arrived", pending_sums.size()));

      $display("Run covered %0d bytes in %0d messages, the longest %0d bytes long.",
               bytes_sent, messages_sent, longest_msg);
      $display("%0d checksums compared, %0d mismatches.", sums_checked, errors);
      if (errors == 0) begin
         $display("** recurrence_byte_checksum_top: PASSED **");
      end else begin
         $display("** recurrence_byte_checksum_top: FAILED **");
      end
      $finish;
   end

endmodule

// File: recurrence_byte_checksum_top.f
rtl/rbc_pkg.sv
rtl/rbc_term.sv
rtl/recurrence_byte_checksum_top.sv
tb/recurrence_byte_checksum_top_tb.sv
